// ===== src/layered_byte_completion_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the layered byte completion tracker
// Concurrent checks on clk with rst as disable; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LAYERED_BYTE_COMPLETION_TRACKER_UNIT_ASSERT_SVH
`define LAYERED_BYTE_COMPLETION_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LBCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbct check failed");
// next-cycle implication
`define LBCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbct check failed");
`else
`define LBCT_ASSERT_IMPL(label, ante, cons)
`define LBCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/lbct_pkg.sv =====
// ----------------------------------------------------------------------------
// lbct_pkg
// Types and constants shared by the layered byte completion tracker.
// ----------------------------------------------------------------------------
package lbct_pkg;

  // record queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int OPC_W   = 3;
  localparam int BYTE_W  = 16;
  localparam int CNT_W   = 24;
  localparam int QCNT_W  = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // register map (byte address bit 2 selects the register)
  localparam logic REG_LAYER_IS_SASL  = 1'b0;
  localparam logic REG_START_PREBYTES = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD_PLAIN  = 3'd0,
    OP_RECORD     = 3'd1,
    OP_WRITTEN    = 3'd2,
    OP_HANDSHAKE  = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRE2,
    ST_LOAD,
    ST_CMP,
    ST_TRIM,
    ST_ACC,
    ST_FINISH
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // one request to the shared add/subtract unit
  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  // ADD: saturated sum, carry = overflow; SUB: difference, carry = a >= b
  typedef struct packed {
    logic [CNT_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

  // queued record: plain part high, encoded length low
  typedef struct packed {
    logic [BYTE_W-1:0] plain;
    logic [BYTE_W-1:0] enc;
  } rec_t;

  typedef struct packed {
    logic             layer_is_sasl;
    logic [CNT_W-1:0] start_prebytes;
  } cfg_t;

endpackage

// ===== src/lbct_in_if.sv =====
// ----------------------------------------------------------------------------
// lbct_in_if
// Command channel: one beat carries an opcode and two byte counts.
// ----------------------------------------------------------------------------
interface lbct_in_if import lbct_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [BYTE_W-1:0] plain_bytes;
  logic [BYTE_W-1:0] encoded_bytes;

  modport source (output valid, output opcode, output plain_bytes,
                  output encoded_bytes, input ready);
  modport sink   (input valid, input opcode, input plain_bytes,
                  input encoded_bytes, output ready);
endinterface

// ===== src/lbct_out_if.sv =====
// ----------------------------------------------------------------------------
// lbct_out_if
// Result channel: one beat per command with counters after the command.
// ----------------------------------------------------------------------------
interface lbct_out_if import lbct_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  plain_done;
  logic              status;
  logic [QCNT_W-1:0] records_queued;
  logic [CNT_W-1:0]  unassigned_plain;

  modport source (output valid, output plain_done, output status,
                  output records_queued, output unassigned_plain, input ready);
  modport sink   (input valid, input plain_done, input status,
                  input records_queued, input unassigned_plain, output ready);
endinterface

// ===== src/layered_byte_completion_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// layered_byte_completion_tracker_unit
// Maps encoded bytes written by the link back to plaintext bytes completed
// for one security or compression layer, using a record queue.
//
//   channel  role    handshake       payload
//   -------  ------  --------------  ----------------------------------------
//   req      sink    valid/ready     opcode, plain_bytes, encoded_bytes
//   rsp      source  valid/ready     plain_done, status, records_queued,
//                                    unassigned_plain
//   apb      slave   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// Commands pass exec and finish; bytes-written adds pre2 when the credit runs
// out and, with tracking on, load for the head read, cmp/acc/load per record
// retired, cmp/trim at a trimmed head (one shared adder, registered queue read).
// req.ready is high only in idle. A finished result sits in the rsp register;
// the next command is taken meanwhile and waits at its end if it is still full.
// rst is synchronous; the record queue needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "layered_byte_completion_tracker_unit_assert.svh"

module layered_byte_completion_tracker_unit import lbct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lbct_in_if.sink           req,
  lbct_out_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  state_t            state, state_next;
  logic [OPC_W-1:0]  op;
  logic [BYTE_W-1:0] pl_in;
  logic [BYTE_W-1:0] enc_in;
  logic [BYTE_W-1:0] wr_cnt, wr_cnt_next;
  logic [CNT_W-1:0]  done, done_next;
  logic              status_r, status_r_next;
  logic [CNT_W-1:0]  unassigned, unassigned_next;
  logic [CNT_W-1:0]  credit, credit_next;
  logic              hs_flag, hs_flag_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              out_load;
  logic              tracking;
  logic              queue_full;
  logic              accept;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  rec_t              mem_wdata;
  rec_t              head_rec;

  lbct_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbct_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  lbct_rec_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head),
    .rdata (head_rec)
  );

  assign tracking   = cfg.layer_is_sasl || hs_flag;
  assign queue_full = (fill == FILL_W'(QUEUE_DEPTH));
  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;

  // pointer wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      unassigned <= '0;
      credit     <= '0;
      hs_flag    <= 1'b0;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
    end else begin
      state      <= state_next;
      unassigned <= unassigned_next;
      credit     <= credit_next;
      hs_flag    <= hs_flag_next;
      head       <= head_next;
      tail       <= tail_next;
      fill       <= fill_next;
    end
  end

  // per-command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.opcode;
      pl_in  <= req.plain_bytes;
      enc_in <= req.encoded_bytes;
    end
    wr_cnt   <= wr_cnt_next;
    done     <= done_next;
    status_r <= status_r_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    wr_cnt_next     = wr_cnt;
    done_next       = done;
    status_r_next   = status_r;
    unassigned_next = unassigned;
    credit_next     = credit;
    hs_flag_next    = hs_flag;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    alu_req.op      = ALU_SUB;
    alu_req.a       = '0;
    alu_req.b       = '0;
    mem_we          = 1'b0;
    mem_waddr       = tail;
    mem_wdata       = '{plain: pl_in, enc: enc_in};
    out_load        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          wr_cnt_next   = req.plain_bytes;
          done_next     = '0;
          status_r_next = 1'b0;
          state_next    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_FINISH;
        case (op)
          OP_ADD_PLAIN: begin
            alu_req.op      = ALU_ADD;
            alu_req.a       = unassigned;
            alu_req.b       = CNT_W'(pl_in);
            unassigned_next = alu_rsp.res;
          end
          OP_RECORD: begin
            if (tracking) begin
              if (queue_full) begin
                status_r_next = 1'b1;
              end else begin
                // clamp plain part to what is unassigned
                alu_req.a = unassigned;
                alu_req.b = CNT_W'(pl_in);
                if (alu_rsp.carry) begin
                  unassigned_next = alu_rsp.res;
                end else begin
                  unassigned_next = '0;
                  mem_wdata.plain = unassigned[BYTE_W-1:0];
                end
                mem_we    = 1'b1;
                tail_next = ptr_inc(tail);
                fill_next = fill + FILL_W'(1);
              end
            end
          end
          OP_WRITTEN: begin
            if (credit != '0) begin
              alu_req.a = credit;
              alu_req.b = CNT_W'(wr_cnt);
              if (alu_rsp.carry) begin
                credit_next = alu_rsp.res;
                done_next   = CNT_W'(wr_cnt);
                wr_cnt_next = '0;
                state_next  = tracking ? ST_LOAD : ST_FINISH;
              end else begin
                done_next  = credit;
                state_next = ST_PRE2;
              end
            end else begin
              state_next = tracking ? ST_LOAD : ST_FINISH;
            end
          end
          OP_HANDSHAKE: begin
            hs_flag_next = 1'b1;
          end
          OP_CLEAR: begin
            unassigned_next = '0;
            head_next       = '0;
            tail_next       = '0;
            fill_next       = '0;
            credit_next     = cfg.start_prebytes;
          end
          default: ;
        endcase
      end

      // remainder after the credit ran out
      ST_PRE2: begin
        alu_req.a   = CNT_W'(wr_cnt);
        alu_req.b   = credit;
        wr_cnt_next = alu_rsp.res[BYTE_W-1:0];
        credit_next = '0;
        state_next  = tracking ? ST_LOAD : ST_FINISH;
      end

      // head entry read in flight
      ST_LOAD: begin
        state_next = (fill == '0) ? ST_FINISH : ST_CMP;
      end

      ST_CMP: begin
        alu_req.a = CNT_W'(wr_cnt);
        alu_req.b = CNT_W'(head_rec.enc);
        if (alu_rsp.carry) begin
          wr_cnt_next = alu_rsp.res[BYTE_W-1:0];
          state_next  = ST_ACC;
        end else begin
          state_next = ST_TRIM;
        end
      end

      // partly covered head: shorten its encoded length
      ST_TRIM: begin
        alu_req.a       = CNT_W'(head_rec.enc);
        alu_req.b       = CNT_W'(wr_cnt);
        mem_we          = 1'b1;
        mem_waddr       = head;
        mem_wdata.plain = head_rec.plain;
        mem_wdata.enc   = alu_rsp.res[BYTE_W-1:0];
        state_next      = ST_FINISH;
      end

      // retire head record
      ST_ACC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = done;
        alu_req.b  = CNT_W'(head_rec.plain);
        done_next  = alu_rsp.res;
        head_next  = ptr_inc(head);
        fill_next  = fill - FILL_W'(1);
        state_next = ST_LOAD;
      end

      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.plain_done       <= done;
      rsp.status           <= status_r;
      rsp.records_queued   <= QCNT_W'({{QCNT_W{1'b0}}, fill});
      rsp.unassigned_plain <= unassigned;
    end
  end

  // checks
  `LBCT_ASSERT_IMPL(a_fill_bound, 1'b1, fill <= FILL_W'(QUEUE_DEPTH))
  `LBCT_ASSERT_IMPL(a_no_pop_empty, state == ST_CMP || state == ST_ACC, fill != '0)
  `LBCT_ASSERT_IMPL(a_drop_only_full, rsp.valid && rsp.status, rsp.records_queued == QCNT_W'(QUEUE_DEPTH))
  `LBCT_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready)

endmodule

// ===== src/lbct_cfg.sv =====
// ----------------------------------------------------------------------------
// lbct_cfg
// APB register file: layer mode and the prebyte credit reload value.
// ----------------------------------------------------------------------------
module lbct_cfg import lbct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LAYER_IS_SASL:  cfg.layer_is_sasl  <= pwdata[0];
        REG_START_PREBYTES: cfg.start_prebytes <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_LAYER_IS_SASL:  prdata = {{(APB_DW-1){1'b0}}, cfg.layer_is_sasl};
      REG_START_PREBYTES: prdata = {{(APB_DW-CNT_W){1'b0}}, cfg.start_prebytes};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== src/lbct_rec_mem.sv =====
// ----------------------------------------------------------------------------
// lbct_rec_mem
// Record queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbct_rec_mem import lbct_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [PTR_W-1:0] waddr,
  input  rec_t             wdata,
  input  logic [PTR_W-1:0] raddr,
  output rec_t             rdata
);

  rec_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lbct_alu.sv =====
// ----------------------------------------------------------------------------
// lbct_alu
// Shared 24-bit adder: saturating add or subtract with a >= b flag.
// ----------------------------------------------------------------------------
module lbct_alu import lbct_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic             is_sub;
  logic [CNT_W-1:0] b_in;
  logic [CNT_W:0]   sum;

  // one carry chain, b inverted for subtract
  assign is_sub = (req.op == ALU_SUB);
  assign b_in   = is_sub ? ~req.b : req.b;
  assign sum    = {1'b0, req.a} + {1'b0, b_in} + {{CNT_W{1'b0}}, is_sub};

  always_comb begin
    rsp.carry = sum[CNT_W];
    if (!is_sub && sum[CNT_W]) begin
      rsp.res = '1;
    end else begin
      rsp.res = sum[CNT_W-1:0];
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for layered_byte_completion_tracker_unit. Commands go
// in on the request channel with random gaps. An in-bench model of the
// record queue, the plaintext counter and the pre-layer credit predicts one
// result beat per command. Result beats are checked field by field while the
// result channel stalls at random. Registers are written over APB between
// phases, once nothing is pending.
// ----------------------------------------------------------------------------
module testbench;
  import lbct_pkg::*;

  localparam int      WATCHDOG_LIMIT = 2000;
  localparam int      DRAIN_CYCLES   = 60;
  localparam int      IDLE_PCT       = 34;
  localparam int      MAX_PRINTS     = 40;
  localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;

  // one expected result beat
  typedef struct packed {
    logic [CNT_W-1:0]  plain_done;
    logic              status;
    logic [QCNT_W-1:0] records_queued;
    logic [CNT_W-1:0]  unassigned_plain;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lbct_in_if  cmd_bus ();
  lbct_out_if res_bus ();

  layered_byte_completion_tracker_unit uut (
    .clk     (clk),
    .rst     (rst),
    .req     (cmd_bus),
    .rsp     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // model state
  rec_t             trk_queue [QUEUE_DEPTH];
  int unsigned      trk_head;
  int unsigned      trk_fill;
  int unsigned      trk_unassigned;
  int unsigned      trk_credit;
  logic             trk_handshake;
  logic             cfg_sasl;
  int unsigned      cfg_prebytes;

  outcome_t         pending_outcomes [$];
  int unsigned      mismatches = 0;
  int unsigned      idle_cycles = 0;
  logic             quiet = 1'b0;  // no idling on either side

  // advance the model by one command, return the result it causes
  function automatic outcome_t apply_command(logic [OPC_W-1:0] op,
                                             logic [BYTE_W-1:0] pb,
                                             logic [BYTE_W-1:0] eb);
    outcome_t    res;
    int unsigned done;
    int unsigned left;
    int unsigned take;
    int unsigned slot;
    logic        tracking;
    done     = 0;
    res      = '0;
    tracking = cfg_sasl || trk_handshake;
    case (op)
      OP_ADD_PLAIN: begin
        trk_unassigned = trk_unassigned + pb;
        if (trk_unassigned > CNT_MAX) trk_unassigned = CNT_MAX;
      end
      OP_RECORD: begin
        if (tracking) begin
          if (trk_fill >= QUEUE_DEPTH) begin
            res.status = 1'b1;
          end else begin
            take = (pb > trk_unassigned) ? trk_unassigned : pb;
            trk_unassigned -= take;
            slot = (trk_head + trk_fill) % QUEUE_DEPTH;
            trk_queue[slot].plain = take[BYTE_W-1:0];
            trk_queue[slot].enc   = eb;
            trk_fill++;
          end
        end
      end
      OP_WRITTEN: begin
        left = pb;
        // pre-layer bytes are paid off first
        if (trk_credit > 0) begin
          if (trk_credit >= left) begin
            done = left;
            trk_credit -= left;
            left = 0;
          end else begin
            done = trk_credit;
            left -= trk_credit;
            trk_credit = 0;
          end
        end
        if (tracking) begin
          while (trk_fill > 0) begin
            if (left < trk_queue[trk_head].enc) begin
              trk_queue[trk_head].enc = BYTE_W'(trk_queue[trk_head].enc - left);
              break;
            end
            left -= trk_queue[trk_head].enc;
            done += trk_queue[trk_head].plain;
            if (done > CNT_MAX) done = CNT_MAX;
            trk_head = (trk_head + 1) % QUEUE_DEPTH;
            trk_fill--;
          end
        end
      end
      OP_HANDSHAKE: trk_handshake = 1'b1;
      OP_CLEAR: begin
        trk_unassigned = 0;
        trk_head       = 0;
        trk_fill       = 0;
        trk_credit     = cfg_prebytes;
      end
      default: ;
    endcase
    res.plain_done       = done[CNT_W-1:0];
    res.records_queued   = trk_fill[QCNT_W-1:0];
    res.unassigned_plain = trk_unassigned[CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("tb: mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want,
               $realtime);
    mismatches++;
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_result();
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch("result beat with nothing pending", res_bus.plain_done, 0);
      return;
    end
    want = pending_outcomes.pop_front();
    if (res_bus.plain_done !== want.plain_done)
      report_mismatch("plain_done", res_bus.plain_done, want.plain_done);
    if (res_bus.status !== want.status)
      report_mismatch("status", res_bus.status, want.status);
    if (res_bus.records_queued !== want.records_queued)
      report_mismatch("records_queued", res_bus.records_queued, want.records_queued);
    if (res_bus.unassigned_plain !== want.unassigned_plain)
      report_mismatch("unassigned_plain", res_bus.unassigned_plain,
                      want.unassigned_plain);
  endtask

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) check_result();
    res_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // send one command beat; valid stays high unless a gap follows
  task automatic send_cmd(logic [OPC_W-1:0] op, logic [BYTE_W-1:0] pb,
                          logic [BYTE_W-1:0] eb);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.opcode        <= op;
    cmd_bus.plain_bytes   <= pb;
    cmd_bus.encoded_bytes <= eb;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_outcomes.push_back(apply_command(op, pb, eb));
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access (register lands here), then idle
  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layer(logic sasl, logic [CNT_W-1:0] prebytes);
    wait_idle();
    write_reg({REG_LAYER_IS_SASL, 2'b00}, APB_DW'(sasl));
    cfg_sasl = sasl;
    write_reg({REG_START_PREBYTES, 2'b00}, APB_DW'(prebytes));
    cfg_prebytes = prebytes;
  endtask

  function automatic logic [BYTE_W-1:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 45) return BYTE_W'($urandom_range(1, 64));
    if (sel < 85) return BYTE_W'($urandom_range(0, 4095));
    return BYTE_W'($urandom_range(0, 65535));
  endfunction

  // TLS mode before the handshake: records ignored, only credit drains
  task automatic test_before_handshake();
    send_cmd(OP_ADD_PLAIN, 16'd0, 16'd0);
    send_cmd(OP_ADD_PLAIN, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_RECORD, 16'd100, 16'd200);
    send_cmd(OP_RECORD, 16'd0, 16'd0);
    send_cmd(OP_WRITTEN, 16'd100, 16'd0);
    send_cmd(OP_WRITTEN, 16'd0, 16'hFFFF);
    for (int op = int'(OP_CLEAR) + 1; op < (1 << OPC_W); op++)
      send_cmd(OPC_W'(op), 16'hFFFF, 16'hFFFF);
    send_cmd(OP_CLEAR, 16'h5555, 16'hAAAA);
    // credit reload on clear, then drained partly and past its end
    set_layer(1'b0, 24'd1000);
    send_cmd(OP_CLEAR, 16'd0, 16'd0);
    send_cmd(OP_WRITTEN, 16'd300, 16'd0);
    send_cmd(OP_WRITTEN, 16'hFFFF, 16'd0);
  endtask

  // zero-length records, clamping, trimming of the head record
  task automatic test_records_after_handshake();
    send_cmd(OP_HANDSHAKE, 16'd0, 16'd0);
    send_cmd(OP_ADD_PLAIN, 16'hFFFF, 16'd0);
    send_cmd(OP_RECORD, 16'hFFFF, 16'd0);
    send_cmd(OP_RECORD, 16'd10, 16'hFFFF);
    send_cmd(OP_ADD_PLAIN, 16'd5, 16'd0);
    send_cmd(OP_RECORD, 16'd100, 16'd3);
    send_cmd(OP_WRITTEN, 16'd0, 16'd0);
    send_cmd(OP_WRITTEN, 16'hFFFE, 16'd0);
    send_cmd(OP_WRITTEN, 16'd1, 16'd0);
    send_cmd(OP_WRITTEN, 16'hFFFF, 16'd0);
    send_cmd(OP_CLEAR, 16'd0, 16'd0);
  endtask

  // fill the queue, overflow it once, retire everything in one beat
  task automatic test_queue_full();
    set_layer(1'b1, 24'd0);
    send_cmd(OP_CLEAR, 16'd0, 16'd0);
    send_cmd(OP_ADD_PLAIN, 16'hFFFF, 16'd0);
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_cmd(OP_RECORD, 16'd4096, 16'd4000);
    send_cmd(OP_WRITTEN, 16'hFFFF, 16'd0);
    send_cmd(OP_WRITTEN, 16'd7, 16'd0);
  endtask

  // unassigned counter pinned at its maximum
  task automatic test_add_saturation();
    repeat (260) send_cmd(OP_ADD_PLAIN, 16'hFFFF, 16'd0);
    send_cmd(OP_RECORD, 16'hFFFF, 16'd1);
    send_cmd(OP_WRITTEN, 16'd1, 16'd0);
    send_cmd(OP_CLEAR, 16'd0, 16'd0);
  endtask

  // mostly add/record/written traffic, some handshakes, clears and junk
  task automatic test_random_traffic(int unsigned count);
    int unsigned sel;
    send_cmd(OP_CLEAR, 16'd0, 16'd0);
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 28)
        send_cmd(OP_ADD_PLAIN, pick_count(), pick_count());
      else if (sel < 58)
        send_cmd(OP_RECORD, pick_count(), pick_count());
      else if (sel < 88)
        send_cmd(OP_WRITTEN, pick_count(), pick_count());
      else if (sel < 91)
        send_cmd(OP_HANDSHAKE, pick_count(), pick_count());
      else if (sel < 93)
        send_cmd(OP_CLEAR, pick_count(), pick_count());
      else if (sel < 96)
        send_cmd(OPC_W'($urandom_range(int'(OP_CLEAR) + 1, (1 << OPC_W) - 1)),
                 pick_count(), pick_count());
      else
        send_cmd(OPC_W'($urandom_range(0, (1 << OPC_W) - 1)),
                 BYTE_W'($urandom_range(0, 65535)), BYTE_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cmd_bus.valid         = 1'b0;
    cmd_bus.opcode        = OP_ADD_PLAIN;
    cmd_bus.plain_bytes   = '0;
    cmd_bus.encoded_bytes = '0;
    res_bus.ready         = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cfg_sasl              = 1'b0;
    cfg_prebytes          = 0;
    trk_handshake         = 1'b0;
    trk_unassigned        = 0;
    trk_head              = 0;
    trk_fill              = 0;
    trk_credit            = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_before_handshake();
    set_layer(1'b0, CNT_W'($urandom_range(1, 4000)));
    test_random_traffic(250);
    test_records_after_handshake();
    test_queue_full();
    test_add_saturation();
    set_layer(1'b1, CNT_W'(CNT_MAX));
    test_random_traffic(250);
    set_layer(1'b0, 24'd0);
    test_random_traffic(300);
    set_layer(1'b1, CNT_W'($urandom_range(0, CNT_MAX)));
    quiet = 1'b1;
    test_random_traffic(400);
    quiet = 1'b0;
    set_layer(1'b0, CNT_W'($urandom_range(0, 65535)));
    test_random_traffic(300);

    // drain, then a tail for stray beats
    wait_idle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== layered_byte_completion_tracker_unit.f =====
+incdir+src
src/lbct_pkg.sv
src/lbct_in_if.sv
src/lbct_out_if.sv
src/lbct_cfg.sv
src/lbct_rec_mem.sv
src/lbct_alu.sv
src/layered_byte_completion_tracker_unit.sv
sim/testbench.sv
